// ===== rtl/sid_pkg.sv =====
// ============================================================================
// sid_pkg: shared types and helpers for the 2d segment intersection core
// Coordinate format, derived arithmetic widths, channel structs and the
// small helper functions used by the pipeline stages.
// ============================================================================
`default_nettype none

package sid_pkg;

  // coordinate width, signed two's complement with 4 fraction bits
  localparam int COORD_BITS = 16;
  // end point differences
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // product of two differences
  localparam int PROD2_BITS = 2 * DIFF_BITS;
  // cross products (difference of two products)
  localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
  // magnitude of a cross product
  localparam int MAG_BITS   = 2 * COORD_BITS + 2;
  // magnitude of numerator times direction component
  localparam int PROD_BITS  = MAG_BITS + COORD_BITS;
  // quotient bits kept before clamping; anything larger saturates the point
  localparam int QUO_BITS   = COORD_BITS + 1;
  // final sum of start point and signed quotient
  localparam int SUM_BITS   = COORD_BITS + 3;
  // latencies
  localparam int SETUP_LAT  = 5;
  localparam int DIV_LAT    = QUO_BITS + 1;
  localparam int PIPE_LAT   = SETUP_LAT + DIV_LAT + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD2_BITS-1:0] prod2_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // request payload
  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } in_t;

  // result payload
  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t cross_x;
    coord_t cross_y;
  } out_t;

  // setup pipeline to divider and side path
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 parallel;
    logic                 neg_x;
    logic                 neg_y;
    coord_t               p0x;
    coord_t               p0y;
    logic [PROD_BITS-1:0] prod_x;
    logic [PROD_BITS-1:0] prod_y;
    logic [MAG_BITS-1:0]  den_mag;
  } front_t;

  // per-request data that bypasses the dividers
  typedef struct packed {
    logic   valid;
    logic   hit;
    logic   parallel;
    logic   neg_x;
    logic   neg_y;
    coord_t p0x;
    coord_t p0y;
  } side_t;

  // divider input
  typedef struct packed {
    logic                 valid;
    logic [PROD_BITS-1:0] num;
    logic [MAG_BITS-1:0]  den;
  } div_in_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic                valid;
    logic                ovf;
    logic [MAG_BITS-1:0] rem;
    logic [MAG_BITS-1:0] den;
    logic [QUO_BITS-1:0] lo;
    logic [QUO_BITS-1:0] quo;
  } div_stage_t;

  // divider result
  typedef struct packed {
    logic                valid;
    logic                ovf;
    logic [QUO_BITS-1:0] quo;
  } div_out_t;

  // sign extend a coordinate to difference width
  function automatic diff_t sx_diff(input coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

  // sign extend a product to cross product width
  function automatic cross_t sx_cross(input prod2_t v);
    return {v[PROD2_BITS-1], v};
  endfunction

  // magnitude of a cross product
  function automatic logic [MAG_BITS-1:0] cross_mag(input cross_t v);
    cross_t n;
    n = -v;
    return v[CROSS_BITS-1] ? n[MAG_BITS-1:0] : v[MAG_BITS-1:0];
  endfunction

  // magnitude of a difference
  function automatic logic [COORD_BITS-1:0] diff_mag(input diff_t v);
    diff_t n;
    n = -v;
    return v[DIFF_BITS-1] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
  endfunction

  // num / den within [0,1], ends included, by comparison without a division
  function automatic logic in_unit(input cross_t num, input cross_t den);
    logic r;
    if (den > 0) begin
      r = (num >= 0) && (num <= den);
    end else begin
      r = (num <= 0) && (num >= den);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sid_setup.sv =====
// ============================================================================
// sid_setup: geometry front end of the segment intersection core
// Five register stages: differences, products, cross products, hit test
// with magnitudes and signs, then the numerator products for the dividers.
// ============================================================================
`default_nettype none

module sid_setup
  import sid_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire in_t    in_data,
  output front_t      front
);

  // stage 1 registers
  logic   s1_valid_r;
  coord_t s1_p0x_r, s1_p0y_r;
  diff_t  s1_d1x_r, s1_d1y_r, s1_d2x_r, s1_d2y_r, s1_wx_r, s1_wy_r;

  // stage 2 registers
  logic   s2_valid_r;
  coord_t s2_p0x_r, s2_p0y_r;
  diff_t  s2_d1x_r, s2_d1y_r;
  prod2_t s2_pa_r, s2_pb_r, s2_pc_r, s2_pd_r, s2_pe_r, s2_pf_r;

  // stage 3 registers
  logic   s3_valid_r;
  coord_t s3_p0x_r, s3_p0y_r;
  diff_t  s3_d1x_r, s3_d1y_r;
  cross_t s3_den_r, s3_snum_r, s3_tnum_r;

  // stage 4 registers
  logic                  s4_valid_r;
  logic                  s4_hit_r, s4_parallel_r, s4_neg_x_r, s4_neg_y_r;
  coord_t                s4_p0x_r, s4_p0y_r;
  logic [MAG_BITS-1:0]   s4_tnum_mag_r, s4_den_mag_r;
  logic [COORD_BITS-1:0] s4_d1x_mag_r, s4_d1y_mag_r;

  // stage 5 register
  front_t front_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      s4_valid_r    <= 1'b0;
      front_r.valid <= 1'b0;
    end else begin
      s1_valid_r    <= in_valid;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      front_r.valid <= s4_valid_r;
    end
  end

  // stage 1: direction vectors and start offset
  always_ff @(posedge clk) begin
    s1_p0x_r <= in_data.a_start_x;
    s1_p0y_r <= in_data.a_start_y;
    s1_d1x_r <= sx_diff(in_data.a_end_x) - sx_diff(in_data.a_start_x);
    s1_d1y_r <= sx_diff(in_data.a_end_y) - sx_diff(in_data.a_start_y);
    s1_d2x_r <= sx_diff(in_data.b_end_x) - sx_diff(in_data.b_start_x);
    s1_d2y_r <= sx_diff(in_data.b_end_y) - sx_diff(in_data.b_start_y);
    s1_wx_r  <= sx_diff(in_data.a_start_x) - sx_diff(in_data.b_start_x);
    s1_wy_r  <= sx_diff(in_data.a_start_y) - sx_diff(in_data.b_start_y);
  end

  // stage 2: the six products
  always_ff @(posedge clk) begin
    s2_p0x_r <= s1_p0x_r;
    s2_p0y_r <= s1_p0y_r;
    s2_d1x_r <= s1_d1x_r;
    s2_d1y_r <= s1_d1y_r;
    s2_pa_r  <= s1_d1x_r * s1_d2y_r;
    s2_pb_r  <= s1_d2x_r * s1_d1y_r;
    s2_pc_r  <= s1_d1x_r * s1_wy_r;
    s2_pd_r  <= s1_d1y_r * s1_wx_r;
    s2_pe_r  <= s1_d2x_r * s1_wy_r;
    s2_pf_r  <= s1_d2y_r * s1_wx_r;
  end

  // stage 3: denominator and the two numerators
  always_ff @(posedge clk) begin
    s3_p0x_r  <= s2_p0x_r;
    s3_p0y_r  <= s2_p0y_r;
    s3_d1x_r  <= s2_d1x_r;
    s3_d1y_r  <= s2_d1y_r;
    s3_den_r  <= sx_cross(s2_pa_r) - sx_cross(s2_pb_r);
    s3_snum_r <= sx_cross(s2_pc_r) - sx_cross(s2_pd_r);
    s3_tnum_r <= sx_cross(s2_pe_r) - sx_cross(s2_pf_r);
  end

  // stage 4: hit test, magnitudes and quotient signs
  always_ff @(posedge clk) begin
    s4_p0x_r      <= s3_p0x_r;
    s4_p0y_r      <= s3_p0y_r;
    s4_parallel_r <= (s3_den_r == '0);
    s4_hit_r      <= in_unit(s3_snum_r, s3_den_r) && in_unit(s3_tnum_r, s3_den_r);
    s4_tnum_mag_r <= cross_mag(s3_tnum_r);
    s4_den_mag_r  <= cross_mag(s3_den_r);
    s4_d1x_mag_r  <= diff_mag(s3_d1x_r);
    s4_d1y_mag_r  <= diff_mag(s3_d1y_r);
    s4_neg_x_r    <= s3_tnum_r[CROSS_BITS-1] ^ s3_d1x_r[DIFF_BITS-1]
                     ^ s3_den_r[CROSS_BITS-1];
    s4_neg_y_r    <= s3_tnum_r[CROSS_BITS-1] ^ s3_d1y_r[DIFF_BITS-1]
                     ^ s3_den_r[CROSS_BITS-1];
  end

  // stage 5: numerator times direction, unsigned
  always_ff @(posedge clk) begin
    front_r.hit      <= s4_hit_r;
    front_r.parallel <= s4_parallel_r;
    front_r.neg_x    <= s4_neg_x_r;
    front_r.neg_y    <= s4_neg_y_r;
    front_r.p0x      <= s4_p0x_r;
    front_r.p0y      <= s4_p0y_r;
    front_r.prod_x   <= s4_tnum_mag_r * s4_d1x_mag_r;
    front_r.prod_y   <= s4_tnum_mag_r * s4_d1y_mag_r;
    front_r.den_mag  <= s4_den_mag_r;
  end

  assign front = front_r;

endmodule

`default_nettype wire

// ===== rtl/sid_div_stage.sv =====
// ============================================================================
// sid_div_stage: one step of the pipelined restoring divider
// Brings in the next numerator bit, subtracts the divisor when it fits
// and appends one quotient bit.
// ============================================================================
`default_nettype none

module sid_div_stage
  import sid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire div_stage_t stg_in,
  output div_stage_t      stg_out
);

  logic [MAG_BITS:0]   trial;
  logic [MAG_BITS+1:0] diff;
  logic                take;
  div_stage_t          stg_nxt;
  div_stage_t          stg_r;

  // trial subtraction
  always_comb begin
    trial = {stg_in.rem, stg_in.lo[QUO_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, stg_in.den};
    take  = !diff[MAG_BITS+1];
  end

  // next remainder and quotient
  always_comb begin
    stg_nxt       = stg_in;
    stg_nxt.rem   = take ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
    stg_nxt.lo    = {stg_in.lo[QUO_BITS-2:0], 1'b0};
    stg_nxt.quo   = {stg_in.quo[QUO_BITS-2:0], take};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else begin
      stg_r.valid <= stg_in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    stg_r.ovf <= stg_nxt.ovf;
    stg_r.rem <= stg_nxt.rem;
    stg_r.den <= stg_nxt.den;
    stg_r.lo  <= stg_nxt.lo;
    stg_r.quo <= stg_nxt.quo;
  end

  assign stg_out = stg_r;

endmodule

`default_nettype wire

// ===== rtl/sid_divider.sv =====
// ============================================================================
// sid_divider: pipelined unsigned divider with overflow clamp
// A setup stage flags quotients too large for the kept quotient bits and
// loads the upper numerator bits; one stage per kept quotient bit follows.
// ============================================================================
`default_nettype none

module sid_divider
  import sid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire div_in_t div_in,
  output div_out_t     div_out
);

  div_stage_t setup_r;
  div_stage_t chain [QUO_BITS+1];

  // setup valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.valid <= 1'b0;
    end else begin
      setup_r.valid <= div_in.valid;
    end
  end

  // overflow check and initial remainder
  always_ff @(posedge clk) begin
    setup_r.ovf <= ({1'b0, div_in.num} >= {div_in.den, {QUO_BITS{1'b0}}});
    setup_r.rem <= {1'b0, div_in.num[PROD_BITS-1:QUO_BITS]};
    setup_r.den <= div_in.den;
    setup_r.lo  <= div_in.num[QUO_BITS-1:0];
    setup_r.quo <= '0;
  end

  assign chain[0] = setup_r;

  // one stage per quotient bit
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
    sid_div_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (chain[i]),
      .stg_out (chain[i+1])
    );
  end

  assign div_out.valid = chain[QUO_BITS].valid;
  assign div_out.ovf   = chain[QUO_BITS].ovf;
  assign div_out.quo   = chain[QUO_BITS].quo;

endmodule

`default_nettype wire

// ===== rtl/segment_intersection_2d_core.sv =====
// ============================================================================
// segment_intersection_2d_core: 2d line segment intersection
// Hit test and meeting point of two segments in signed 4-fraction-bit
// coordinates, fully pipelined.
// ============================================================================
// A request is taken on every clock edge where start is high; busy is always
// low, so a new pair of segments can enter each cycle. Every request gives
// exactly one result, presented for a single cycle with out_valid high.
// The request passes 5 setup stages, 18 divider stages and the output
// stage. The result cannot be held off, so the receiver must take it in
// that cycle. The divider stages form two parallel bit-per-stage
// quotient pipelines, one for each of the x and y components of the
// meeting point.
`default_nettype none

module segment_intersection_2d_core
  import sid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  front_t   front;
  div_in_t  div_x_in, div_y_in;
  div_out_t div_x_out, div_y_out;
  side_t    side_in;
  side_t    side_r [DIV_LAT];
  side_t    side_last;
  out_t     out_nxt;
  logic     out_valid_r;
  out_t     out_data_r;

  // no backpressure on the request side
  assign busy = 1'b0;

  sid_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_data  (in_data),
    .front    (front)
  );

  // split front end output into divider inputs and bypass data
  always_comb begin
    div_x_in.valid   = front.valid;
    div_x_in.num     = front.prod_x;
    div_x_in.den     = front.den_mag;
    div_y_in.valid   = front.valid;
    div_y_in.num     = front.prod_y;
    div_y_in.den     = front.den_mag;
    side_in.valid    = front.valid;
    side_in.hit      = front.hit;
    side_in.parallel = front.parallel;
    side_in.neg_x    = front.neg_x;
    side_in.neg_y    = front.neg_y;
    side_in.p0x      = front.p0x;
    side_in.p0y      = front.p0y;
  end

  sid_divider u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_x_in),
    .div_out (div_x_out)
  );

  sid_divider u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_y_in),
    .div_out (div_y_out)
  );

  // bypass delay line; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0].valid <= side_in.valid;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i].valid <= side_r[i-1].valid;
      end
    end
    side_r[0].hit      <= side_in.hit;
    side_r[0].parallel <= side_in.parallel;
    side_r[0].neg_x    <= side_in.neg_x;
    side_r[0].neg_y    <= side_in.neg_y;
    side_r[0].p0x      <= side_in.p0x;
    side_r[0].p0y      <= side_in.p0y;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_r[i].hit      <= side_r[i-1].hit;
      side_r[i].parallel <= side_r[i-1].parallel;
      side_r[i].neg_x    <= side_r[i-1].neg_x;
      side_r[i].neg_y    <= side_r[i-1].neg_y;
      side_r[i].p0x      <= side_r[i-1].p0x;
      side_r[i].p0y      <= side_r[i-1].p0y;
    end
  end

  assign side_last = side_r[DIV_LAT-1];

  // start point plus signed quotient, saturated
  function automatic coord_t finish_coord(input logic ovf, input logic neg,
                                          input logic [QUO_BITS-1:0] quo,
                                          input coord_t p0);
    logic        [SUM_BITS-1:0] qz;
    logic signed [SUM_BITS-1:0] qs, sum, maxv, minv;
    coord_t                     res;
    qz   = {{(SUM_BITS-QUO_BITS){1'b0}}, quo};
    qs   = neg ? -qz : qz;
    sum  = {{(SUM_BITS-COORD_BITS){p0[COORD_BITS-1]}}, p0} + qs;
    maxv = {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    minv = ~maxv;
    if (ovf) begin
      res = neg ? COORD_MIN : COORD_MAX;
    end else if (sum > maxv) begin
      res = COORD_MAX;
    end else if (sum < minv) begin
      res = COORD_MIN;
    end else begin
      res = sum[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // result assembly; parallel segments give no hit and the origin
  always_comb begin
    out_nxt.parallel = side_last.parallel;
    if (side_last.parallel) begin
      out_nxt.hit     = 1'b0;
      out_nxt.cross_x = '0;
      out_nxt.cross_y = '0;
    end else begin
      out_nxt.hit     = side_last.hit;
      out_nxt.cross_x = finish_coord(div_x_out.ovf, side_last.neg_x, div_x_out.quo,
                                     side_last.p0x);
      out_nxt.cross_y = finish_coord(div_y_out.ovf, side_last.neg_y, div_y_out.quo,
                                     side_last.p0y);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every request is matched by a result strobe after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("request did not produce a result after pipeline latency");

  // no result without a request
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching request");

  // dividers and bypass line stay in step
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    (div_x_out.valid == div_y_out.valid) && (div_x_out.valid == side_last.valid))
    else $error("divider and bypass valid bits out of step");

  // parallel result carries no hit and the origin
  a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.parallel) |->
      (!out_data.hit && (out_data.cross_x == '0) && (out_data.cross_y == '0)))
    else $error("parallel result with hit or nonzero point");

endmodule

`default_nettype wire
